### rtl/core/edd_pkg.sv
package edd_pkg;

	// Line buffer and frame size limits
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Fixed field widths
	localparam int PIX_W = 8;
	localparam int ERR_W = 9;
	localparam int FW_W  = 8;
	localparam int FH_W  = 7;
	localparam int THR_W = 8;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THRESHOLD    = 2'd2
	} cfg_reg_t;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic [COL_W-1:0]        col_t;

	// Position of the pixel at the head of the stream
	typedef struct packed {
		col_t col;
		logic last_col;
		logic last_row;
	} pos_t;

	// Line buffer updates from one diffused pixel
	typedef struct packed {
		logic wr_en;     // entry to the lower left
		col_t wr_addr;
		err_t wr_data;
		logic tail_en;   // entry straight below, last column only
		col_t tail_addr;
		err_t tail_data;
	} line_upd_t;

endpackage

### rtl/core/edd_stream_if.sv
// Pixel channel
interface edd_pix_if import edd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source(output valid, output pixel_value, input ready);
	modport sink(input valid, input pixel_value, output ready);
endinterface

// Dithered result channel
interface edd_res_if ();
	logic valid;
	logic ready;
	logic out_bit;
	logic row_end;
	logic frame_end;

	modport source(output valid, output out_bit, output row_end, output frame_end, input ready);
	modport sink(input valid, input out_bit, input row_end, input frame_end, output ready);
endinterface

### rtl/core/edd_pos_ctrl.sv
module edd_pos_ctrl import edd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [FW_W-1:0] frame_width,
	input  logic [FH_W-1:0] frame_height,
	output pos_t            pos
);

	logic [COL_W:0]   width_eff;
	logic [ROW_W:0]   height_eff;
	col_t             col_q;
	logic [ROW_W-1:0] row_q;

	// Clamp frame size to 1..max
	always_comb begin
		if (frame_width == '0) begin
			width_eff = (COL_W+1)'(1);
		end else if (int'(frame_width) > MAX_WIDTH) begin
			width_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			width_eff = (COL_W+1)'(frame_width);
		end
		if (frame_height == '0) begin
			height_eff = (ROW_W+1)'(1);
		end else if (int'(frame_height) > MAX_HEIGHT) begin
			height_eff = (ROW_W+1)'(MAX_HEIGHT);
		end else begin
			height_eff = (ROW_W+1)'(frame_height);
		end
	end

	// A position at or past the last index ends its row / frame
	always_comb begin
		pos.col      = col_q;
		pos.last_col = ({1'b0, col_q} + (COL_W+1)'(1)) >= width_eff;
		pos.last_row = ({1'b0, row_q} + (ROW_W+1)'(1)) >= height_eff;
	end

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

### rtl/core/edd_err_line.sv
module edd_err_line import edd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_en,
	input  col_t      rd_addr,
	input  line_upd_t upd,
	output err_t      pend
);

	err_t             mem [MAX_WIDTH];
	logic [MAX_WIDTH-1:0] valid_q;

	// Deferred write of the entry below a last-column pixel
	logic tail_vld_q;
	col_t tail_addr_q;
	err_t tail_data_q;

	logic wr_go;
	col_t wr_addr;
	err_t wr_data;
	logic tail_wr;

	err_t mem_rd_s1;
	logic vld_rd_s1;
	logic byp_hit_s1;
	err_t byp_s1;
	logic byp_hit;
	err_t byp_val;

	// Single write port: lower-left write first, tail in a free cycle
	always_comb begin
		tail_wr = tail_vld_q && !upd.wr_en;
		wr_go   = upd.wr_en || tail_vld_q;
		wr_addr = upd.wr_en ? upd.wr_addr : tail_addr_q;
		wr_data = upd.wr_en ? upd.wr_data : tail_data_q;
	end

	// Newest value for the read address that the memory will not return
	always_comb begin
		byp_hit = 1'b1;
		byp_val = upd.tail_data;
		if (upd.tail_en && upd.tail_addr == rd_addr) begin
			byp_val = upd.tail_data;
		end else if (wr_go && wr_addr == rd_addr) begin
			byp_val = wr_data;
		end else if (tail_vld_q && tail_addr_q == rd_addr) begin
			byp_val = tail_data_q;
		end else begin
			byp_hit = 1'b0;
		end
	end

	// Line memory
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
			byp_s1    <= byp_val;
		end
	end

	// Entry valid bits, tail holding register, read-side flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			tail_vld_q <= 1'b0;
			vld_rd_s1  <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else begin
			if (wr_go) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (upd.tail_en) begin
				tail_vld_q <= 1'b1;
			end else if (tail_wr) begin
				tail_vld_q <= 1'b0;
			end
			if (rd_en) begin
				vld_rd_s1  <= valid_q[rd_addr];
				byp_hit_s1 <= byp_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.tail_en) begin
			tail_addr_q <= upd.tail_addr;
			tail_data_q <= upd.tail_data;
		end
	end

	// Unwritten entries read as zero
	assign pend = byp_hit_s1 ? byp_s1 : (vld_rd_s1 ? mem_rd_s1 : '0);

endmodule

### rtl/core/edd_diffuse.sv
module edd_diffuse import edd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [PIX_W-1:0] pixel_value,
	input  pos_t             pos,
	input  logic [THR_W-1:0] threshold,
	input  err_t             pend,
	input  logic             out_ready,
	output logic             in_ready,
	output line_upd_t        upd,
	output logic             out_valid,
	output logic             out_bit,
	output logic             row_end,
	output logic             frame_end
);

	localparam err_t ERR_MAX = 9'sh0FF;
	localparam err_t ERR_MIN = 9'sh100;

	// Signed divide by 16, truncating toward zero
	function automatic logic signed [12:0] trunc16(input logic signed [12:0] x);
		logic signed [12:0] b;
		b = x + (x[12] ? 13'sd15 : 13'sd0);
		return b >>> 4;
	endfunction

	function automatic err_t sat9(input logic signed [12:0] x);
		if (x > 13'sd255) begin
			return ERR_MAX;
		end else if (x < -13'sd256) begin
			return ERR_MIN;
		end else begin
			return x[ERR_W-1:0];
		end
	endfunction

	logic             valid_s1;
	logic [PIX_W-1:0] px_s1;
	pos_t             pos_s1;

	err_t right_carry_q;
	err_t below_left_q;
	err_t below_here_q;

	logic out_valid_q;
	logic out_bit_q;
	logic row_end_q;
	logic frame_end_q;

	logic               fire;
	logic signed [10:0] val;
	logic signed [10:0] err;
	logic               white;
	logic signed [12:0] err13;
	logic signed [12:0] q7, q3, q5, q1;
	err_t               here_sat;
	logic               no_down;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// Working value, decision and error terms
	always_comb begin
		val   = $signed({3'b000, px_s1}) + 11'(pend) + 11'(right_carry_q);
		white = val > $signed({3'b000, threshold});
		err   = white ? val - 11'sd255 : val;
		err13 = 13'(err);
		q7    = trunc16(err13 * 13'sd7);
		q3    = trunc16(err13 * 13'sd3);
		q5    = trunc16(err13 * 13'sd5);
		q1    = trunc16(err13);
		here_sat = sat9(13'(below_here_q) + q5);
		no_down  = pos_s1.last_row;
	end

	// Line buffer writes; the last row leaves zeros behind
	always_comb begin
		upd.wr_en     = fire && (pos_s1.col != '0);
		upd.wr_addr   = pos_s1.col - COL_W'(1);
		upd.wr_data   = no_down ? '0 : sat9(13'(below_left_q) + q3);
		upd.tail_en   = fire && pos_s1.last_col;
		upd.tail_addr = pos_s1.col;
		upd.tail_data = no_down ? '0 : here_sat;
	end

	// Stage 1 control and diffusion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			right_carry_q <= '0;
			below_left_q  <= '0;
			below_here_q  <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				right_carry_q <= pos_s1.last_col ? '0 : sat9(q7);
				if (no_down || pos_s1.last_col) begin
					below_left_q <= '0;
					below_here_q <= '0;
				end else begin
					below_left_q <= here_sat;
					below_here_q <= sat9(q1);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			px_s1  <= pixel_value;
			pos_s1 <= pos;
		end
		if (fire) begin
			out_bit_q   <= white;
			row_end_q   <= pos_s1.last_col;
			frame_end_q <= pos_s1.last_col && pos_s1.last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign out_bit   = out_bit_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule

### rtl/core/error_diffusion_dither_core.sv
// Floyd-Steinberg dither core: 8-bit gray in, one bit out per pixel.
// Result path: the pixel beat and its line read are registered, then the diffusion result is registered.
// Throughput: one pixel per cycle while the result channel is not stalled; set by the right-carry loop and the single
// write port of the 128-entry error line, with forwarding from the in-flight writes.
// Reset: counters, carries and output valid clear; line entries read as zero via valid bits,
// no clearing pass; width 128, height 64, threshold 128.
module error_diffusion_dither_core import edd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	edd_pix_if.sink     pixel,
	edd_res_if.source   result,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [THR_W-1:0] threshold_q;

	logic      accept;
	logic      in_ready;
	pos_t      pos;
	err_t      pend;
	line_upd_t upd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(MAX_WIDTH);
			frame_height_q <= FH_W'(MAX_HEIGHT);
			threshold_q    <= THR_W'(128);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign pixel.ready = in_ready;
	assign accept      = pixel.valid && in_ready;

	edd_pos_ctrl u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pos          (pos)
	);

	edd_err_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos.col),
		.upd     (upd),
		.pend    (pend)
	);

	edd_diffuse u_diffuse (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.pixel_value (pixel.pixel_value),
		.pos         (pos),
		.threshold   (threshold_q),
		.pend        (pend),
		.out_ready   (result.ready),
		.in_ready    (in_ready),
		.upd         (upd),
		.out_valid   (result.valid),
		.out_bit     (result.out_bit),
		.row_end     (result.row_end),
		.frame_end   (result.frame_end)
	);

endmodule

### rtl/core/edd_checker.sv
module edd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_bit,
	input logic row_end,
	input logic frame_end
);

	logic [2:0] outstanding_q;

	// Pixels taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 3'(in_valid && in_ready)
				- 3'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_bit, row_end, frame_end}))
		else $error("stalled result beat changed");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q <= 3'd2) && (!out_valid || outstanding_q != 3'd0))
		else $error("result without pixel, or too many pixels in flight");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 3'd0 |-> in_ready)
		else $error("empty pipeline not ready for a pixel");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind error_diffusion_dither_core edd_checker u_edd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_bit   (result.out_bit),
	.row_end   (result.row_end),
	.frame_end (result.frame_end)
);
